// File: sv/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared types, codes and the control program of the prefix-code bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 4;
	localparam int CODE_W = 8;
	localparam int IDX_W  = 6;
	localparam int CMD_W  = 2;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

	localparam logic [SYM_W-1:0] UNMATCHED_SYM = 8'd63;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_TAKE,
		S_DONE
	} step_t;

	typedef enum logic [1:0] {
		C_NONE,
		C_GO,
		C_EMPTY,
		C_NORES
	} cond_t;

	typedef struct packed {
		logic  in_rdy;
		logic  look;
		logic  take;
		logic  done;
		logic  hold;
		cond_t cond;
		step_t jump;
		step_t seq;
	} ctl_t;

	typedef struct packed {
		logic go;
		logic empty;
		logic nores;
		logic stall;
	} stat_t;

	function automatic ctl_t ucode(input step_t step);
		ctl_t cw;
		cw = '0;
		unique case (step)
			S_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond   = C_GO;
				cw.jump   = S_LOOK;
				cw.seq    = S_IDLE;
			end
			S_LOOK: begin
				cw.look = 1'b1;
				cw.cond = C_EMPTY;
				cw.jump = S_DONE;
				cw.seq  = S_TAKE;
			end
			S_TAKE: begin
				cw.take = 1'b1;
				cw.hold = 1'b1;
				cw.cond = C_NORES;
				cw.jump = S_DONE;
				cw.seq  = S_LOOK;
			end
			S_DONE: begin
				cw.done = 1'b1;
				cw.hold = 1'b1;
				cw.cond = C_NONE;
				cw.jump = S_IDLE;
				cw.seq  = S_IDLE;
			end
			default: cw = '0;
		endcase
		return cw;
	endfunction

endpackage

// File: sv/huffman_table_bit_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_table_bit_decoder_top
// Table-driven prefix-code decoder for a serial bit stream.
// ----------------------------------------------------------------------------
// A table write beat is taken in the idle step. A data bit or flush beat is
// accepted in the idle step, then runs one look/take pass of the microprogram
// for each symbol that it yields, and a last look or take finds the end of the
// run before the done step hands over the last result. Each pass reads the
// symbol memory, with registered read data, after the parallel code compare.
// Results pass through a pending register into one output register, and the
// sequencer waits in the take or done step while that output is held.
module huffman_table_bit_decoder_top #(
	parameter int TABLE_ENTRIES = 36,
	parameter int MAX_CODE_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [htbd_pkg::CMD_W-1:0]  command,
	input  logic [htbd_pkg::IDX_W-1:0]  entry_index,
	input  logic [htbd_pkg::SYM_W-1:0]  entry_symbol,
	input  logic [htbd_pkg::LEN_W-1:0]  entry_length,
	input  logic [htbd_pkg::CODE_W-1:0] entry_code,
	input  logic                        stream_bit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [htbd_pkg::SYM_W-1:0]  symbol,
	output logic                        last_of_run,
	output logic                        message_end
);
	import htbd_pkg::*;

	ctl_t  ctl;
	stat_t stat;

	htbd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	htbd_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.in_valid     (in_valid),
		.command      (command),
		.entry_index  (entry_index),
		.entry_symbol (entry_symbol),
		.entry_length (entry_length),
		.entry_code   (entry_code),
		.stream_bit   (stream_bit),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.symbol       (symbol),
		.last_of_run  (last_of_run),
		.message_end  (message_end)
	);

	assign in_ready = ctl.in_rdy;

endmodule

// File: sv/htbd_ram.sv
// ----------------------------------------------------------------------------
// htbd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module htbd_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/htbd_seq.sv
// ----------------------------------------------------------------------------
// htbd_seq
// Step counter and control store; conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module htbd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  htbd_pkg::stat_t stat,
	output htbd_pkg::ctl_t  ctl
);
	import htbd_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  cond_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		ctl = ucode(step_q);
		unique case (ctl.cond)
			C_NONE:  cond_hit = 1'b0;
			C_GO:    cond_hit = stat.go;
			C_EMPTY: cond_hit = stat.empty;
			C_NORES: cond_hit = stat.nores;
			default: cond_hit = 1'b0;
		endcase
		priority if (cond_hit) begin
			step_d = ctl.jump;
		end else if (ctl.hold && stat.stall) begin
			step_d = step_q;
		end else begin
			step_d = ctl.seq;
		end
	end

endmodule

// File: sv/htbd_dp.sv
// ----------------------------------------------------------------------------
// htbd_dp
// Datapath: code lanes with parallel compare, symbol memory, bit window,
// pending result and output register.
// ----------------------------------------------------------------------------
module htbd_dp #(
	parameter int TABLE_ENTRIES = 36,
	parameter int MAX_CODE_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  htbd_pkg::ctl_t                 ctl,
	output htbd_pkg::stat_t                stat,
	input  logic                           in_valid,
	input  logic [htbd_pkg::CMD_W-1:0]     command,
	input  logic [htbd_pkg::IDX_W-1:0]     entry_index,
	input  logic [htbd_pkg::SYM_W-1:0]     entry_symbol,
	input  logic [htbd_pkg::LEN_W-1:0]     entry_length,
	input  logic [htbd_pkg::CODE_W-1:0]    entry_code,
	input  logic                           stream_bit,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [htbd_pkg::SYM_W-1:0]     symbol,
	output logic                           last_of_run,
	output logic                           message_end
);
	import htbd_pkg::*;

	localparam int W    = MAX_CODE_BITS;
	localparam int CW   = $clog2(W + 1);
	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int RW   = SYM_W + LEN_W;
	localparam int SW   = 5;

	logic [W-1:0]  code_q  [TABLE_ENTRIES];
	logic [W-1:0]  mask_q  [TABLE_ENTRIES];
	logic          valid_q [TABLE_ENTRIES];
	logic [W-1:0]  win_q;
	logic [CW-1:0] cnt_q;
	logic          flush_q;
	logic          hit_q;
	logic          pend_vld_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic          out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic          out_last_q;
	logic          out_end_q;

	logic          accept;
	logic          wr_slot;
	logic [IW-1:0] slot;
	logic          len_ok;
	logic [15:0]   low_m;
	logic [CODE_W-1:0] code_m;
	logic [W+CODE_W-1:0] code_ext;
	logic [W-1:0]  code_al;
	logic [W-1:0]  mask_al;
	logic [W-1:0]  cnt_mask;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic          hit_any;
	logic [IW-1:0] hit_idx;
	logic [RW-1:0] ram_rdata;
	logic [SYM_W-1:0] ram_sym;
	logic [LEN_W-1:0] ram_len;
	logic [SYM_W-1:0] res_sym;
	logic [LEN_W-1:0] rem_len;
	logic [SW-1:0] cnt_rem;
	logic          nores;
	logic          stall;
	logic          take_load;
	logic          take_push;
	logic          done_push;
	logic          push;

	// input decode and entry alignment
	assign accept   = in_valid && ctl.in_rdy;
	assign wr_slot  = accept && (command == CMD_WRITE)
		&& ({1'b0, entry_index} < (IDX_W + 1)'(TABLE_ENTRIES));
	assign slot     = entry_index[IW-1:0];
	assign len_ok   = (entry_length != '0) && (SW'(entry_length) <= SW'(W));
	assign low_m    = (16'd1 << entry_length) - 16'd1;
	assign code_m   = entry_code & low_m[CODE_W-1:0];
	assign code_ext = (W + CODE_W)'(code_m) << W;
	assign code_al  = W'(code_ext >> entry_length);
	assign mask_al  = ~({W{1'b1}} >> entry_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (wr_slot && (slot == IW'(i))) begin
					valid_q[i] <= len_ok;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (wr_slot && (slot == IW'(i))) begin
				code_q[i] <= code_al;
				mask_q[i] <= mask_al;
			end
		end
	end

	// parallel compare against the window's leading bits
	assign cnt_mask = ~({W{1'b1}} >> cnt_q);

	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = valid_q[i] && ((mask_q[i] & ~cnt_mask) == '0)
				&& (((win_q ^ code_q[i]) & mask_q[i]) == '0);
		end
	end

	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
		end
	end

	htbd_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_ENTRIES)
	) u_sym_ram (
		.clk     (clk),
		.wr_en   (wr_slot),
		.wr_addr (slot),
		.wr_data ({entry_symbol, entry_length}),
		.rd_en   (ctl.look),
		.rd_addr (hit_idx),
		.rd_data (ram_rdata)
	);

	assign ram_sym = ram_rdata[RW-1:LEN_W];
	assign ram_len = ram_rdata[LEN_W-1:0];

	// result selection
	assign res_sym   = hit_q ? ram_sym : UNMATCHED_SYM;
	assign rem_len   = hit_q ? ram_len : LEN_W'(1);
	assign cnt_rem   = SW'(cnt_q) - SW'(rem_len);
	assign nores     = !hit_q && !flush_q && (cnt_q != CW'(W));
	assign stall     = pend_vld_q && out_valid_q && !out_ready;
	assign take_load = ctl.take && !nores && !stall;
	assign take_push = take_load && pend_vld_q;
	assign done_push = ctl.done && pend_vld_q && !stall;
	assign push      = take_push || done_push;

	assign stat.go    = accept && ((command == CMD_DATA) || (command == CMD_FLUSH));
	assign stat.empty = (cnt_q == '0);
	assign stat.nores = nores;
	assign stat.stall = stall;

	// window, run flags and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			cnt_q      <= '0;
			flush_q    <= 1'b0;
			hit_q      <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (accept && (command == CMD_DATA)) begin
				win_q <= win_q | ({stream_bit, {(W-1){1'b0}}} >> cnt_q);
				cnt_q <= cnt_q + CW'(1);
			end else if (take_load) begin
				win_q <= win_q << rem_len;
				cnt_q <= cnt_rem[CW-1:0];
			end
			if (stat.go) begin
				flush_q <= (command == CMD_FLUSH);
			end
			if (ctl.look) begin
				hit_q <= hit_any;
			end
			if (take_load) begin
				pend_vld_q <= 1'b1;
			end else if (done_push) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_load) begin
			pend_sym_q <= res_sym;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_sym_q  <= pend_sym_q;
			out_last_q <= done_push;
			out_end_q  <= flush_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign symbol      = out_sym_q;
	assign last_of_run = out_last_q;
	assign message_end = out_end_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(cnt_q) <= SW'(W))
		else $error("window count above code width");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.in_rdy |-> !pend_vld_q)
		else $error("pending result left when taking a new beat");

	a_idle_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.in_rdy |-> (SW'(cnt_q) < SW'(W)))
		else $error("window full between beats");

	a_hit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take && hit_q) |-> ((ram_len != '0) && (SW'(ram_len) <= SW'(cnt_q))))
		else $error("matched entry length out of window");
`endif

endmodule

// File: bench/huffman_table_bit_decoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_bit_decoder_top_test
// Self-checking bench for the table-driven prefix-code bit decoder.
// A short table of directed beats covers reset, extreme codes, ignored writes,
// unknown commands and writes that land while bits are pending. Random prefix-free
// code tables are then loaded and the bench streams encoded messages mixed with
// noise beats. A local decoder predicts every symbol, and the bench compares
// each output beat field by field while both sides stall at random.
// ----------------------------------------------------------------------------
module huffman_table_bit_decoder_top_test;

	import htbd_pkg::*;

	localparam int TABLE_SLOTS = 36;
	localparam int CODE_BITS = 8;
	localparam int NO_SLOT = -1;
	localparam int PREDICT = -1;
	localparam int BEATS_PER_PHASE = 16;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	typedef struct {
		logic [SYM_W-1:0] sym;
		logic             last;
		logic             mend;
	} decoded_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  idx;
		logic [SYM_W-1:0]  sym;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
		logic              bitv;
		int                known_n;
		logic [SYM_W-1:0]  known_sym;
		logic              known_end;
	} row_t;

	localparam row_t DIRECTED_ROWS [24] = '{
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_FLUSH,   6'd0,  8'h00, 4'd0,  8'h00, 1'b0, 1,       UNMATCHED_SYM, 1'b1},
		'{CMD_FLUSH,   6'd0,  8'h00, 4'd0,  8'h00, 1'b0, 0,       8'h00,         1'b0},
		'{CMD_UNKNOWN, 6'd63, 8'hff, 4'd15, 8'hff, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_WRITE,   6'd0,  8'hff, 4'd8,  8'hff, 1'b0, 0,       8'h00,         1'b0},
		'{CMD_WRITE,   6'd35, 8'h00, 4'd1,  8'hfe, 1'b0, 0,       8'h00,         1'b0},
		'{CMD_WRITE,   6'd63, 8'h41, 4'd1,  8'h01, 1'b0, 0,       8'h00,         1'b0},
		'{CMD_WRITE,   6'd1,  8'h42, 4'd15, 8'h01, 1'b0, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b0, 1,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 0,       8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, 1,       8'hff,         1'b0},
		'{CMD_DATA,    6'd9,  8'h5a, 4'd3,  8'h33, 1'b1, PREDICT, 8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, PREDICT, 8'h00,         1'b0},
		'{CMD_WRITE,   6'd2,  8'h43, 4'd2,  8'h03, 1'b0, PREDICT, 8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b0, PREDICT, 8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b1, PREDICT, 8'h00,         1'b0},
		'{CMD_DATA,    6'd0,  8'h00, 4'd0,  8'h00, 1'b0, PREDICT, 8'h00,         1'b0},
		'{CMD_FLUSH,   6'd21, 8'ha5, 4'd7,  8'h5c, 1'b1, PREDICT, 8'h00,         1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command = CMD_WRITE;
	logic [IDX_W-1:0]  entry_index = '0;
	logic [SYM_W-1:0]  entry_symbol = '0;
	logic [LEN_W-1:0]  entry_length = '0;
	logic [CODE_W-1:0] entry_code = '0;
	logic              stream_bit = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [SYM_W-1:0]  symbol;
	logic              last_of_run;
	logic              message_end;

	// decoder shadow state
	logic [SYM_W-1:0]  code_symbol [TABLE_SLOTS];
	logic [LEN_W-1:0]  code_len [TABLE_SLOTS];
	logic [CODE_W-1:0] code_bits [TABLE_SLOTS];
	int unsigned       win_bits;
	int unsigned       win_count;

	decoded_t    predicted [$];
	decoded_t    pending_symbols [$];
	int unsigned leaf_code [$];
	int unsigned leaf_len [$];

	int send_idle_pct = 9;
	int recv_idle_pct = 84;
	int beat_count = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	huffman_table_bit_decoder_top u_top (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.command,
		.entry_index,
		.entry_symbol,
		.entry_length,
		.entry_code,
		.stream_bit,
		.out_valid,
		.out_ready,
		.symbol,
		.last_of_run,
		.message_end
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int find_slot();
		int unsigned l;
		int hit;
		hit = NO_SLOT;
		// scan downward so the lowest matching slot wins
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			l = code_len[i];
			if (l != 0 && l <= CODE_BITS && l <= win_count &&
					(((win_bits >> (win_count - l)) ^ code_bits[i]) & ((1 << l) - 1)) == 0) begin
				hit = i;
			end
		end
		return hit;
	endfunction

	task automatic predict_symbols(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code, input logic bitv);
		int slot;
		int unsigned take_n;
		logic flushing;
		logic stuck;
		decoded_t d;
		predicted.delete();
		case (cmd)
			CMD_WRITE: begin
				if (idx < TABLE_SLOTS) begin
					code_symbol[idx] = sym;
					code_len[idx] = len;
					code_bits[idx] = code;
				end
			end
			CMD_DATA, CMD_FLUSH: begin
				if (cmd == CMD_DATA) begin
					win_bits = ((win_bits << 1) | bitv) & ((1 << (win_count + 1)) - 1);
					win_count++;
				end
				flushing = (cmd == CMD_FLUSH);
				stuck = 1'b0;
				while (win_count != 0 && !stuck) begin
					slot = find_slot();
					take_n = 0;
					if (slot != NO_SLOT) begin
						d.sym = code_symbol[slot];
						take_n = code_len[slot];
					end else if (flushing || win_count >= CODE_BITS) begin
						d.sym = UNMATCHED_SYM;
						take_n = 1;
					end
					if (take_n == 0) begin
						stuck = 1'b1;
					end else begin
						win_count -= take_n;
						win_bits &= (1 << win_count) - 1;
						d.last = 1'b0;
						d.mend = flushing;
						predicted.push_back(d);
					end
				end
				if (predicted.size() > 0) begin
					d = predicted.pop_back();
					d.last = 1'b1;
					predicted.push_back(d);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
			input logic [SYM_W-1:0] sym, input logic [LEN_W-1:0] len,
			input logic [CODE_W-1:0] code, input logic bitv, input int known_n,
			input logic [SYM_W-1:0] known_sym, input logic known_end);
		decoded_t d;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		command = cmd;
		entry_index = idx;
		entry_symbol = sym;
		entry_length = len;
		entry_code = code;
		stream_bit = bitv;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_symbols(cmd, idx, sym, len, code, bitv);
		if (known_n == PREDICT) begin
			foreach (predicted[i]) pending_symbols.push_back(predicted[i]);
		end else if (known_n > 0) begin
			d.sym = known_sym;
			d.last = 1'b1;
			d.mend = known_end;
			pending_symbols.push_back(d);
		end
		if (cmd != CMD_UNKNOWN && !(cmd == CMD_WRITE && idx >= TABLE_SLOTS)) beat_count++;
		@(negedge clk);
	endtask

	task automatic send_noise();
		send_beat(CMD_W'($urandom_range(3, 0)), IDX_W'($urandom_range(63, 0)),
			SYM_W'($urandom), LEN_W'($urandom_range(15, 0)), CODE_W'($urandom),
			1'($urandom), PREDICT, 8'h00, 1'b0);
	endtask

	// random complete prefix-free code, written to shuffled slots
	task automatic load_code_table();
		int slot_order [TABLE_SLOTS];
		logic in_use [TABLE_SLOTS];
		int target;
		int j;
		int t;
		int unsigned c;
		int unsigned l;
		logic [CODE_W-1:0] code;
		leaf_code.delete();
		leaf_len.delete();
		leaf_code.push_back(0);
		leaf_len.push_back(0);
		target = $urandom_range(9, 3);
		while (leaf_code.size() < target) begin
			j = $urandom_range(leaf_code.size() - 1, 0);
			if (leaf_len[j] < CODE_BITS) begin
				c = leaf_code[j];
				l = leaf_len[j];
				leaf_code[j] = c << 1;
				leaf_len[j] = l + 1;
				leaf_code.push_back((c << 1) | 1);
				leaf_len.push_back(l + 1);
			end
		end
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			slot_order[i] = i;
			in_use[i] = 1'b0;
		end
		for (int i = TABLE_SLOTS - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = slot_order[i];
			slot_order[i] = slot_order[j];
			slot_order[j] = t;
		end
		foreach (leaf_code[k]) begin
			in_use[slot_order[k]] = 1'b1;
			// junk above the code length must be ignored
			code = CODE_W'(leaf_code[k] | ($urandom << leaf_len[k]));
			send_beat(CMD_WRITE, IDX_W'(slot_order[k]), SYM_W'($urandom),
				LEN_W'(leaf_len[k]), code, 1'($urandom), PREDICT, 8'h00, 1'b0);
		end
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (!in_use[i] && code_len[i] != 0 && code_len[i] <= CODE_BITS) begin
				send_beat(CMD_WRITE, IDX_W'(i), SYM_W'($urandom),
					$urandom_range(1, 0) ? 4'd0 : LEN_W'($urandom_range(15, 9)),
					CODE_W'($urandom), 1'($urandom), PREDICT, 8'h00, 1'b0);
			end
		end
	endtask

	task automatic send_message();
		int n;
		int k;
		n = $urandom_range(5, 1);
		for (int m = 0; m < n; m++) begin
			if ($urandom_range(99) < 12) send_noise();
			k = $urandom_range(leaf_code.size() - 1, 0);
			for (int b = leaf_len[k] - 1; b >= 0; b--) begin
				send_beat(CMD_DATA, IDX_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
					CODE_W'($urandom), 1'((leaf_code[k] >> b) & 1), PREDICT, 8'h00, 1'b0);
			end
		end
		if ($urandom_range(99) < 70) begin
			send_beat(CMD_FLUSH, IDX_W'($urandom), SYM_W'($urandom), LEN_W'($urandom),
				CODE_W'($urandom), 1'($urandom), PREDICT, 8'h00, 1'b0);
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_symbols.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, symbol %0d", symbol));
			end else begin
				want = pending_symbols.pop_front();
				if (symbol !== want.sym)
					report_mismatch($sformatf("symbol got %0d want %0d", symbol, want.sym));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("last_of_run got %b want %b", last_of_run, want.last));
				if (message_end !== want.mend)
					report_mismatch($sformatf("message_end got %b want %b", message_end, want.mend));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("huffman_table_bit_decoder_top test failed");
			$finish;
		end
	end

	initial begin
		int phase_start;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			code_symbol[i] = '0;
			code_len[i] = '0;
			code_bits[i] = '0;
		end
		win_bits = 0;
		win_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 84 : 0;
			recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 9 : 0;
			if (phase == 0) begin
				foreach (DIRECTED_ROWS[r]) begin
					send_beat(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].sym,
						DIRECTED_ROWS[r].len, DIRECTED_ROWS[r].code, DIRECTED_ROWS[r].bitv,
						DIRECTED_ROWS[r].known_n, DIRECTED_ROWS[r].known_sym,
						DIRECTED_ROWS[r].known_end);
				end
			end
			load_code_table();
			phase_start = beat_count;
			while (beat_count - phase_start < BEATS_PER_PHASE) send_message();
		end
		in_valid = 1'b0;
		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("huffman_table_bit_decoder_top test passed");
		end else begin
			$display("huffman_table_bit_decoder_top test failed");
		end
		$finish;
	end

endmodule
